FILE: hw/rtl/btot_pkg.sv
// Shared types and constants for the box/triangle overlap test.
`default_nettype none
package btot_pkg;

  localparam int unsigned FieldWidth = 32;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_VERTEX = 2'd1,
    HIT_POINT  = 2'd2
  } hit_kind_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] tri_a_x;
    logic signed [FieldWidth-1:0] tri_a_y;
    logic signed [FieldWidth-1:0] tri_b_x;
    logic signed [FieldWidth-1:0] tri_b_y;
    logic signed [FieldWidth-1:0] tri_c_x;
    logic signed [FieldWidth-1:0] tri_c_y;
    logic signed [FieldWidth-1:0] box_min_x;
    logic signed [FieldWidth-1:0] box_min_y;
    logic signed [FieldWidth-1:0] box_max_x;
    logic signed [FieldWidth-1:0] box_max_y;
  } in_word_t;

  typedef struct packed {
    logic      overlaps;
    hit_kind_t hit_kind;
  } out_word_t;

endpackage
`default_nettype wire

FILE: hw/rtl/btot_point_test.sv
// Pipelined exact point-in-triangle test for one box point.
`default_nettype none
module btot_point_test #(
  parameter int unsigned CW = 33  // doubled coordinate width
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] ax,
  input  wire logic signed [CW-1:0] ay,
  input  wire logic signed [CW-1:0] bx,
  input  wire logic signed [CW-1:0] by,
  input  wire logic signed [CW-1:0] cx,
  input  wire logic signed [CW-1:0] cy,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  output logic                      hit
);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;

  // Stage 1: differences and range checks.
  logic signed [DW-1:0] v1x, v1y, v2x, v2y, wx, wy, ux, uy, tx, ty;
  logic rng_ab, rng_bc, rng_ca;

  function automatic logic in_rng(input logic signed [CW-1:0] p,
                                  input logic signed [CW-1:0] e0,
                                  input logic signed [CW-1:0] e1);
    logic signed [CW-1:0] lo, hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (lo <= p) && (p <= hi);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      v1x <= DW'(bx) - DW'(ax);  v1y <= DW'(by) - DW'(ay);
      v2x <= DW'(cx) - DW'(ax);  v2y <= DW'(cy) - DW'(ay);
      wx  <= DW'(px) - DW'(ax);  wy  <= DW'(py) - DW'(ay);
      ux  <= DW'(cx) - DW'(bx);  uy  <= DW'(cy) - DW'(by);
      tx  <= DW'(px) - DW'(bx);  ty  <= DW'(py) - DW'(by);
      rng_ab <= in_rng(px, ax, bx) && in_rng(py, ay, by);
      rng_bc <= in_rng(px, bx, cx) && in_rng(py, by, cy);
      rng_ca <= in_rng(px, cx, ax) && in_rng(py, cy, ay);
    end
  end

  // Stage 2: products.
  logic signed [PW-1:0] p_d0, p_d1, p_a0, p_a1, p_b0, p_b1, p_e0, p_e1;
  logic signed [PW-1:0] p_f0, p_f1, p_g0, p_g1;
  logic r_ab, r_bc, r_ca;
  always_ff @(posedge clk) begin
    if (en) begin
      p_d0 <= v1x * v2y;  p_d1 <= v1y * v2x;
      p_a0 <= wx * v2y;   p_a1 <= wy * v2x;
      p_b0 <= v1x * wy;   p_b1 <= v1y * wx;
      p_e0 <= v1x * wy;   p_e1 <= v1y * wx;  // AB edge against P-A
      p_f0 <= ux * ty;    p_f1 <= uy * tx;   // BC edge against P-B
      p_g0 <= v2x * wy;   p_g1 <= v2y * wx;  // CA edge against P-A
      r_ab <= rng_ab;  r_bc <= rng_bc;  r_ca <= rng_ca;
    end
  end

  // Stage 3: determinants.
  logic signed [SW-1:0] d, na, nb, ce, cf, cg;
  logic q_ab, q_bc, q_ca;
  always_ff @(posedge clk) begin
    if (en) begin
      d  <= SW'(p_d0) - SW'(p_d1);
      na <= SW'(p_a0) - SW'(p_a1);
      nb <= SW'(p_b0) - SW'(p_b1);
      ce <= SW'(p_e0) - SW'(p_e1);
      cf <= SW'(p_f0) - SW'(p_f1);
      cg <= SW'(p_g0) - SW'(p_g1);
      q_ab <= r_ab;  q_bc <= r_bc;  q_ca <= r_ca;
    end
  end

  // Stage 4: final compares.
  logic signed [SW-1:0] rem;
  logic degen_hit, pos_hit, neg_hit;
  always_comb begin
    rem       = d - na - nb;
    degen_hit = (ce == '0 && q_ab) || (cf == '0 && q_bc) || (cg == '0 && q_ca);
    pos_hit   = !na[SW-1] && !nb[SW-1] && !rem[SW-1];
    neg_hit   = (na[SW-1] || na == '0) && (nb[SW-1] || nb == '0)
                && (rem[SW-1] || rem == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d == '0) begin
        hit <= degen_hit;
      end else if (!d[SW-1]) begin
        hit <= pos_hit;
      end else begin
        hit <= neg_hit;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/box_triangle_overlap_test_core.sv
// Top level of the box/triangle overlap test pipeline.
`default_nettype none
// Looks per word for overlap of a 2D triangle and an axis-aligned box,
// using exact tests only. A vertex inside the box (bounds included) gives
// hit kind 1; otherwise the four box corners and the box centre are tested
// against the triangle with an exact barycentric test (edges included,
// degenerate triangles handled as segments), giving kind 2. One word is
// accepted every cycle unless the pipe is stalled. From acceptance to the
// result being shown, stage one forms differences, stage two the products,
// stage three the determinants, stage four the sign decisions and stage
// five merges the five point tests with the vertex test. The whole pipe
// advances only when its output register is free or being taken, so a
// stall on the result side holds every stage and nothing is lost.
module box_triangle_overlap_test_core #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire btot_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output btot_pkg::out_word_t     out_word
);
  import btot_pkg::*;

  // Every decision is exact and scale free, so the fraction bit count only
  // documents the format.
  localparam int unsigned CW    = COORD_WIDTH + 1 + (FRACTION_BITS * 0);
  localparam int unsigned Depth = 5;

  logic en;
  logic [Depth-1:0] vld;

  // The pipe moves whenever the last stage is empty or being drained.
  assign en       = !vld[Depth-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Coordinates are cut to COORD_WIDTH, read as signed and doubled so that
  // the box centre is exact.
  function automatic logic signed [CW-1:0] dbl(input logic [FieldWidth-1:0] raw);
    logic signed [COORD_WIDTH-1:0] s;
    s = COORD_WIDTH'(raw);
    return {s, 1'b0};
  endfunction

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, lx, ly, hx, hy, mx, my;
  logic signed [CW:0] sx, sy;
  always_comb begin
    ax = dbl(in_word.tri_a_x);   ay = dbl(in_word.tri_a_y);
    bx = dbl(in_word.tri_b_x);   by = dbl(in_word.tri_b_y);
    cx = dbl(in_word.tri_c_x);   cy = dbl(in_word.tri_c_y);
    lx = dbl(in_word.box_min_x); ly = dbl(in_word.box_min_y);
    hx = dbl(in_word.box_max_x); hy = dbl(in_word.box_max_y);
    sx = (CW+1)'(lx) + (CW+1)'(hx);
    sy = (CW+1)'(ly) + (CW+1)'(hy);
    mx = sx[CW:1];
    my = sy[CW:1];
  end

  // Vertex-in-box test, delayed to line up with the point tests.
  logic vhit;
  logic [Depth-2:0] vpipe;
  always_comb begin
    vhit = (ax >= lx && ax <= hx && ay >= ly && ay <= hy) ||
           (bx >= lx && bx <= hx && by >= ly && by <= hy) ||
           (cx >= lx && cx <= hx && cy >= ly && cy <= hy);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      vpipe <= {vpipe[Depth-3:0], vhit};
    end
  end

  logic signed [CW-1:0] qx [5];
  logic signed [CW-1:0] qy [5];
  logic [4:0] ins;
  always_comb begin
    qx[0] = lx; qy[0] = ly;
    qx[1] = hx; qy[1] = hy;
    qx[2] = hx; qy[2] = ly;
    qx[3] = lx; qy[3] = hy;
    qx[4] = mx; qy[4] = my;
  end

  for (genvar g = 0; g < 5; g++) begin : g_pt
    btot_point_test #(.CW(CW)) u_pt (
      .clk, .en,
      .ax, .ay, .bx, .by, .cx, .cy,
      .px(qx[g]), .py(qy[g]),
      .hit(ins[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vpipe[Depth-2]) begin
        out_word.hit_kind <= HIT_VERTEX;
        out_word.overlaps <= 1'b1;
      end else if (|ins) begin
        out_word.hit_kind <= HIT_POINT;
        out_word.overlaps <= 1'b1;
      end else begin
        out_word.hit_kind <= HIT_NONE;
        out_word.overlaps <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/btot_checker.sv
// Port checker for the box/triangle overlap test and its bind.
`default_nettype none
module btot_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire btot_pkg::out_word_t out_word
);
  import btot_pkg::*;

  a_ovl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.overlaps == (out_word.hit_kind != HIT_NONE)))
    else $error("overlaps disagrees with hit kind");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.hit_kind != 2'd3))
    else $error("invalid hit kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("result changed while stalled");

  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");
endmodule

bind box_triangle_overlap_test_core btot_checker u_btot_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_word
);
`default_nettype wire
